// ===== src/mesi_pkg.sv =====
// ---------------------------------------------------------------------------
// mesi_pkg : shared types and constants of the MESI snoop coherence block
// Line states, request kinds, the snoop result bundle and helper functions.
// ---------------------------------------------------------------------------
package mesi_pkg;

  localparam int CORE_COUNT_DEF     = 4;
  localparam int LINES_PER_CORE_DEF = 4;
  localparam int ADDR_BITS_DEF      = 16;

  localparam logic [31:0] MEM_SCALE = 32'd10;

  typedef enum logic [1:0] {
    ST_MODIFIED  = 2'd0,
    ST_EXCLUSIVE = 2'd1,
    ST_SHARED    = 2'd2,
    ST_INVALID   = 2'd3
  } line_state_t;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        was_miss;
    logic [1:0]  copies_invalidated;
  } snoop_res_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== src/mesi_ram.sv =====
// ---------------------------------------------------------------------------
// mesi_ram : generic single-port-write RAM with registered read
// One write and one read address per cycle; read data held while re is low.
// ---------------------------------------------------------------------------
module mesi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mesi_snoop.sv =====
// ---------------------------------------------------------------------------
// mesi_snoop : snoop and update of one cache index across all cores
// Resolves hit, sharing, memory fill and invalidation for one access.
// ---------------------------------------------------------------------------
module mesi_snoop #(
  parameter int NC = mesi_pkg::CORE_COUNT_DEF,
  parameter int AW = mesi_pkg::ADDR_BITS_DEF,
  parameter int CW = $clog2(NC)
) (
  input  logic                    req_type,
  input  logic [CW-1:0]           me,
  input  logic [AW-1:0]           addr,
  input  logic [31:0]             wdata,
  input  logic [NC-1:0][1:0]      st_cur,
  input  logic [NC-1:0][AW-1:0]   tag_cur,
  input  logic [NC-1:0][31:0]     data_cur,
  output logic [NC-1:0][1:0]      st_new,
  output logic [NC-1:0][AW-1:0]   tag_new,
  output logic [NC-1:0][31:0]     data_new,
  output logic [NC-1:0]           kill,
  output mesi_pkg::snoop_res_t    res
);
  import mesi_pkg::*;

  logic [NC-1:0] hold;
  logic          found;
  logic [CW-1:0] src;
  logic [4:0]    nkill;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      hold[c] = (st_cur[c] != ST_INVALID) && (tag_cur[c] == addr);
    end
  end

  always_comb begin
    found = 1'b0;
    src   = '0;
    for (int c = 0; c < NC; c++) begin
      if (!found && (CW'(c) != me) && hold[c]) begin
        found = 1'b1;
        src   = CW'(c);
      end
    end
  end

  always_comb begin
    st_new   = st_cur;
    tag_new  = tag_cur;
    data_new = data_cur;
    kill     = '0;
    res      = '0;
    nkill    = '0;
    if (req_type == REQ_WRITE) begin
      if (!(hold[me] && (st_cur[me] == ST_MODIFIED || st_cur[me] == ST_EXCLUSIVE))) begin
        res.was_miss = !hold[me];
        for (int c = 0; c < NC; c++) begin
          if ((CW'(c) != me) && hold[c]) begin
            kill[c]   = 1'b1;
            st_new[c] = ST_INVALID;
          end
        end
      end
      tag_new[me]  = addr;
      data_new[me] = wdata;
      st_new[me]   = ST_MODIFIED;
    end else begin
      if (hold[me]) begin
        res.read_data = data_cur[me];
      end else begin
        res.was_miss = 1'b1;
        if (found) begin
          st_new[src]  = ST_SHARED;
          data_new[me] = data_cur[src];
          st_new[me]   = ST_SHARED;
        end else begin
          data_new[me] = 32'(addr) * MEM_SCALE;
          st_new[me]   = ST_EXCLUSIVE;
        end
        tag_new[me]   = addr;
        res.read_data = data_new[me];
      end
    end
    for (int c = 0; c < NC; c++) begin
      nkill = nkill + 5'(kill[c]);
    end
    res.copies_invalidated = (nkill > 5'd3) ? 2'd3 : nkill[1:0];
  end

endmodule

// ===== src/mesi_snoop_coherence.sv =====
// ---------------------------------------------------------------------------
// mesi_snoop_coherence : snooping MESI coherence over per-core caches
// Direct-mapped caches indexed by address modulo the line count, all cores'
// lines at one index held in one RAM row and resolved in a single pass.
//
//   channel | dir | fields
//   s_*     | in  | tuser: req_type ; tdata: core_index, address, write_data
//   m_*     | out | tdata: read_data, was_miss, copies_invalidated,
//           |     |        miss_total, invalidation_total
//
// One beat per cycle sustained while m_tready allows; a beat passes the input,
// index, snoop and result registers on its way to m_tvalid. The index row is
// read from RAM in the index stage and forwarded when the beat ahead writes the same row.
// rst clears stage valids, row valid bits and counters; no clearing pass.
// A stalled output holds every stage, so s_tready follows m_tready.
// ---------------------------------------------------------------------------
module mesi_snoop_coherence #(
  parameter int CORE_COUNT     = mesi_pkg::CORE_COUNT_DEF,
  parameter int LINES_PER_CORE = mesi_pkg::LINES_PER_CORE_DEF,
  parameter int ADDR_BITS      = mesi_pkg::ADDR_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // core_index, address, write_data, zero pad
  input  logic         s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // read_data, was_miss, copies_invalidated,
                                  // miss_total, invalidation_total, zero pad
);
  import mesi_pkg::*;

  localparam int NC    = CORE_COUNT;
  localparam int L     = LINES_PER_CORE;
  localparam int AW    = ADDR_BITS;
  localparam int CW    = $clog2(NC);
  localparam int IW    = (L > 1) ? $clog2(L) : 1;
  localparam int ROW_W = NC * (2 + AW + 32);

  logic en;

  // stage 1
  logic        vld1;
  logic        type1;
  logic [1:0]  core1;
  logic [15:0] addr1;
  logic [31:0] wdata1;
  logic [4:0]  ci_ext;
  logic [4:0]  ci_red;
  logic [AW+15:0] addr_ext;

  // stage 2
  logic          vld2;
  logic          type2;
  logic [CW-1:0] me2;
  logic [AW-1:0] addrm2;
  logic [31:0]   wdata2;
  logic [IW-1:0] idx2;

  // stage 3
  logic             vld3;
  logic             type3;
  logic [CW-1:0]    me3;
  logic [AW-1:0]    addrm3;
  logic [31:0]      wdata3;
  logic [IW-1:0]    idx3;
  logic             rv3;
  logic             fwd3;
  logic [ROW_W-1:0] fwd_row3;
  logic [ROW_W-1:0] ram_q;
  logic [ROW_W-1:0] row_cur;
  logic [ROW_W-1:0] row_new;

  logic [NC-1:0][1:0]    st_row;
  logic [NC-1:0][AW-1:0] tag_row;
  logic [NC-1:0][31:0]   data_row;
  logic [NC-1:0][1:0]    st_cur;
  logic [NC-1:0][1:0]    st_new;
  logic [NC-1:0][AW-1:0] tag_new;
  logic [NC-1:0][31:0]   data_new;
  logic [NC-1:0]         kill;
  snoop_res_t            res;

  logic [L-1:0]          row_vld;
  logic [NC-1:0][31:0]   miss_cnt;
  logic [NC-1:0][31:0]   inval_cnt;
  logic [31:0]           miss_tot;

  // result register
  logic        out_vld;
  logic [31:0] rdata_o;
  logic        miss_o;
  logic [1:0]  copies_o;
  logic [31:0] miss_tot_o;
  logic [31:0] inval_tot_o;

  assign en       = !out_vld || m_tready;
  assign s_tready = en;
  assign m_tvalid = out_vld;
  assign m_tdata  = {5'b0, inval_tot_o, miss_tot_o, copies_o, miss_o, rdata_o};

  // wrap core index and mask address
  assign ci_ext   = {3'b0, core1};
  assign ci_red   = (ci_ext >= 5'(NC)) ? ci_ext - 5'(NC) : ci_ext;
  assign addr_ext = {{AW{1'b0}}, addr1};

  generate
    if (L == 1) begin : g_idx_one
      assign idx2 = '0;
    end else if ((L & (L - 1)) == 0) begin : g_idx_pow2
      logic [AW+IW-1:0] apad;
      assign apad = {{IW{1'b0}}, addrm2};
      assign idx2 = apad[IW-1:0];
    end else begin : g_idx_recip
      localparam int          LB    = $clog2(L);
      localparam int          MW    = AW + 1;
      localparam logic [63:0] RECIP = ((64'd1 << (AW + LB)) + 64'(L) - 64'd1) / 64'(L);
      logic [AW+MW-1:0] prod1;
      logic [AW+MW-1:0] shifted1;
      logic [AW-1:0]    q2;
      logic [AW+IW-1:0] apad;
      logic [AW+IW-1:0] qpad;
      logic [AW+IW-1:0] diff;

      assign prod1    = (AW+MW)'(addr_ext[AW-1:0]) * (AW+MW)'(RECIP[MW-1:0]);
      assign shifted1 = prod1 >> (AW + LB);

      always_ff @(posedge clk) begin
        if (en) begin
          q2 <= shifted1[AW-1:0];
        end
      end

      assign apad = {{IW{1'b0}}, addrm2};
      assign qpad = {{IW{1'b0}}, q2};
      assign diff = apad - qpad * (AW+IW)'(L);
      assign idx2 = diff[IW-1:0];
    end
  endgenerate

  mesi_ram #(
    .WIDTH (ROW_W),
    .DEPTH (L)
  ) u_rows (
    .clk   (clk),
    .we    (en && vld3),
    .waddr (idx3),
    .wdata (row_new),
    .re    (en),
    .raddr (idx2),
    .rdata (ram_q)
  );

  assign row_cur = fwd3 ? fwd_row3 : ram_q;
  assign {data_row, tag_row, st_row} = row_cur;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      st_cur[c] = (rv3 || fwd3) ? st_row[c] : ST_INVALID;
    end
  end

  mesi_snoop #(
    .NC (NC),
    .AW (AW),
    .CW (CW)
  ) u_snoop (
    .req_type (type3),
    .me       (me3),
    .addr     (addrm3),
    .wdata    (wdata3),
    .st_cur   (st_cur),
    .tag_cur  (tag_row),
    .data_cur (data_row),
    .st_new   (st_new),
    .tag_new  (tag_new),
    .data_new (data_new),
    .kill     (kill),
    .res      (res)
  );

  assign row_new  = {data_new, tag_new, st_new};
  assign miss_tot = res.was_miss ? sat_inc(miss_cnt[me3]) : miss_cnt[me3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      out_vld   <= 1'b0;
      rv3       <= 1'b0;
      fwd3      <= 1'b0;
      row_vld   <= '0;
      miss_cnt  <= '0;
      inval_cnt <= '0;
    end else if (en) begin
      vld1    <= s_tvalid;
      vld2    <= vld1;
      vld3    <= vld2;
      out_vld <= vld3;
      rv3     <= row_vld[idx2];
      fwd3    <= vld3 && vld2 && (idx2 == idx3);
      if (vld3) begin
        row_vld[idx3] <= 1'b1;
        miss_cnt[me3] <= miss_tot;
        for (int c = 0; c < NC; c++) begin
          if (kill[c]) begin
            inval_cnt[c] <= sat_inc(inval_cnt[c]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      type1       <= s_tuser;
      core1       <= s_tdata[1:0];
      addr1       <= s_tdata[17:2];
      wdata1      <= s_tdata[49:18];
      type2       <= type1;
      me2         <= ci_red[CW-1:0];
      addrm2      <= addr_ext[AW-1:0];
      wdata2      <= wdata1;
      type3       <= type2;
      me3         <= me2;
      addrm3      <= addrm2;
      wdata3      <= wdata2;
      idx3        <= idx2;
      fwd_row3    <= row_new;
      rdata_o     <= res.read_data;
      miss_o      <= res.was_miss;
      copies_o    <= res.copies_invalidated;
      miss_tot_o  <= miss_tot;
      inval_tot_o <= inval_cnt[me3];
    end
  end

endmodule

// ===== dv/mesi_snoop_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mesi_snoop_checker : result predictor and scoreboard for the MESI block
// Watches both stream channels. Each request beat accepted on the slave side
// updates a private copy of the cache states, tags, data and per-core
// counters, and queues the result it predicts. Each master beat is compared,
// field by field, with the oldest queued result.
// ---------------------------------------------------------------------------
module mesi_snoop_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [55:0]  s_tdata,   // core_index, address, write_data, zero pad
  input  logic         s_tuser,   // req_type
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,   // read_data, was_miss, copies_invalidated,
                                  // miss_total, invalidation_total, zero pad
  output int unsigned  fail_count,
  output int unsigned  pending
);
  import mesi_pkg::*;

  localparam int CORES = CORE_COUNT_DEF;
  localparam int LINES = LINES_PER_CORE_DEF;

  typedef struct packed {
    logic [31:0] inval_total;
    logic [31:0] miss_total;
    logic [1:0]  killed;
    logic        was_miss;
    logic [31:0] read_data;
  } access_res_t;

  line_state_t line_st   [CORES][LINES];
  logic [15:0] line_tag  [CORES][LINES];
  logic [31:0] line_data [CORES][LINES];
  logic [31:0] miss_cnt  [CORES];
  logic [31:0] inval_cnt [CORES];

  access_res_t due_results [$];
  access_res_t want, seen;
  int unsigned mismatches = 0;
  int unsigned depth = 0;

  assign fail_count = mismatches;
  assign pending    = depth;

  function automatic logic [31:0] bump_sat(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic bit holds(input int c, input int idx, input logic [15:0] a);
    return line_st[c][idx] != ST_INVALID && line_tag[c][idx] == a;
  endfunction

  task automatic predict_access(input req_kind_t kind, input logic [1:0] core,
                                input logic [15:0] addr, input logic [31:0] wdata,
                                output access_res_t r);
    int  idx;
    int  n;
    bit  hit;
    bit  found;
    idx   = addr % LINES;
    r     = '0;
    n     = 0;
    found = 1'b0;
    hit   = holds(core, idx, addr);
    if (kind == REQ_READ) begin
      if (hit) begin
        r.read_data = line_data[core][idx];
      end else begin
        r.was_miss = 1'b1;
        miss_cnt[core] = bump_sat(miss_cnt[core]);
        // take the copy of the lowest-numbered other holder
        for (int c = 0; c < CORES; c++) begin
          if (!found && c != core && holds(c, idx, addr)) begin
            line_st[c][idx]      = ST_SHARED;
            line_data[core][idx] = line_data[c][idx];
            line_st[core][idx]   = ST_SHARED;
            found = 1'b1;
          end
        end
        if (!found) begin
          line_data[core][idx] = {16'd0, addr} * MEM_SCALE;
          line_st[core][idx]   = ST_EXCLUSIVE;
        end
        line_tag[core][idx] = addr;
        r.read_data = line_data[core][idx];
      end
    end else begin
      if (!(hit && (line_st[core][idx] == ST_MODIFIED ||
                    line_st[core][idx] == ST_EXCLUSIVE))) begin
        if (!hit) begin
          r.was_miss = 1'b1;
          miss_cnt[core] = bump_sat(miss_cnt[core]);
        end
        for (int c = 0; c < CORES; c++) begin
          if (c != core && holds(c, idx, addr)) begin
            line_st[c][idx] = ST_INVALID;
            inval_cnt[c] = bump_sat(inval_cnt[c]);
            n++;
          end
        end
        r.killed = (n > 3) ? 2'd3 : 2'(n);
      end
      // a dirty victim is simply overwritten
      line_tag[core][idx]  = addr;
      line_data[core][idx] = wdata;
      line_st[core][idx]   = ST_MODIFIED;
    end
    r.miss_total  = miss_cnt[core];
    r.inval_total = inval_cnt[core];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CORES; c++) begin
        for (int i = 0; i < LINES; i++) begin
          line_st[c][i]   = ST_INVALID;
          line_tag[c][i]  = '0;
          line_data[c][i] = '0;
        end
        miss_cnt[c]  = '0;
        inval_cnt[c] = '0;
      end
      due_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen = m_tdata[98:0];
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected: %h", $realtime, seen);
        end else begin
          want = due_results.pop_front();
          if (seen.read_data !== want.read_data || seen.was_miss !== want.was_miss ||
              seen.killed !== want.killed || seen.miss_total !== want.miss_total ||
              seen.inval_total !== want.inval_total) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: rd/miss/inv/mtot/itot exp %h/%b/%0d/%0d/%0d got %h/%b/%0d/%0d/%0d",
                       $realtime, want.read_data, want.was_miss, want.killed,
                       want.miss_total, want.inval_total, seen.read_data,
                       seen.was_miss, seen.killed, seen.miss_total,
                       seen.inval_total);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_access(req_kind_t'(s_tuser), s_tdata[1:0], s_tdata[17:2],
                       s_tdata[49:18], want);
        due_results.push_back(want);
      end
    end
    depth = due_results.size();
  end

endmodule

// ===== dv/tb_mesi_snoop_coherence.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_mesi_snoop_coherence : stimulus and verdict for the MESI snoop block
// Directed accesses walk one line through every coherence transition, then
// random accesses over a small, shifting set of hot addresses create sharing,
// invalidations and dirty victims. Requests come in bursts with gaps; the
// result side stalls on its own pattern. Checking sits in mesi_snoop_checker.
// ---------------------------------------------------------------------------
module tb_mesi_snoop_coherence;
  import mesi_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SEGMENTS   = 8;
  localparam int SEG_ITEMS  = 200;

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [55:0]  s_tdata  = '0;
  logic         s_tuser  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int          burst_left = 0;
  int          stall_left = 0;
  int          ready_cyc  = 0;
  int          idle_cyc   = 0;
  logic [15:0] hot [6];

  mesi_snoop_coherence uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata
  );

  mesi_snoop_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stretches of full throughput alternate with stretches of random stalls
  always @(negedge clk) begin
    ready_cyc++;
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (ready_cyc[8:7] != 2'd0 && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_access(input req_kind_t kind, input logic [1:0] core,
                             input logic [15:0] addr, input logic [31:0] wdata);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'd0, wdata, addr, core};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random;
    req_kind_t   kind;
    logic [15:0] addr;
    kind = ($urandom_range(0, 99) < 55) ? REQ_READ : REQ_WRITE;
    addr = ($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, 5)]
                                        : 16'($urandom_range(0, 65535));
    send_access(kind, 2'($urandom_range(0, 3)), addr, $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one line through every transition, then a dirty victim
    send_access(REQ_READ,  2'd0, 16'h0005, 32'h0);
    send_access(REQ_READ,  2'd0, 16'h0005, 32'h0);
    send_access(REQ_WRITE, 2'd0, 16'h0005, 32'h1234_5678);
    send_access(REQ_READ,  2'd1, 16'h0005, 32'h0);
    send_access(REQ_READ,  2'd2, 16'h0005, 32'h0);
    send_access(REQ_READ,  2'd3, 16'h0005, 32'h0);
    send_access(REQ_WRITE, 2'd1, 16'h0005, 32'hCAFE_F00D);
    send_access(REQ_READ,  2'd0, 16'h0005, 32'h0);
    send_access(REQ_WRITE, 2'd2, 16'h0005, 32'h0BAD_BEEF);
    send_access(REQ_WRITE, 2'd3, 16'h0009, 32'h1111_1111);
    send_access(REQ_WRITE, 2'd2, 16'h0009, 32'h2222_2222);
    send_access(REQ_READ,  2'd2, 16'h0005, 32'h0);
    send_access(REQ_READ,  2'd3, 16'hFFFF, 32'h0);
    send_access(REQ_WRITE, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
    send_access(REQ_READ,  2'd0, 16'hFFFF, 32'h0);
    send_access(REQ_WRITE, 2'd1, 16'h0000, 32'h8000_0000);
    send_access(REQ_READ,  2'd1, 16'h0000, 32'h0);
    send_access(REQ_WRITE, 2'd0, 16'h0000, 32'h0);
    send_access(REQ_READ,  2'd2, 16'h0000, 32'h0);
    send_access(REQ_WRITE, 2'd2, 16'h0000, 32'h7FFF_FFFF);
    drain();

    for (int s = 0; s < SEGMENTS; s++) begin
      for (int i = 0; i < 4; i++) hot[i] = {14'($urandom), 2'(i)};
      hot[4] = 16'($urandom);
      hot[5] = 16'($urandom);
      for (int n = 0; n < SEG_ITEMS; n++) send_random();
      if (s == SEGMENTS / 2) drain();
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
